### src/nelm_pkg.sv
// Package for the NFA edge-list matcher: sizes, request and register codes,
// edge and item record types, state-bit helper. No dependencies.
package nelm_pkg;

    localparam int STATE_CNT = 64;
    localparam int EDGE_CNT  = 128;
    localparam int EIDX_W    = $clog2(EDGE_CNT);
    localparam int ECNT_W    = 8;
    localparam int STATE_W   = 6;
    localparam int SYM_W     = 8;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_CHAR  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_COUNT = 2'd0,
        REG_ACCEPT     = 2'd1,
        REG_SPARE_2    = 2'd2,
        REG_SPARE_3    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic               eps;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

    typedef struct packed {
        t_req               req;
        logic [6:0]         idx;
        logic               eps;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [SYM_W-1:0]   chr;
    } t_item;

    typedef struct packed {
        logic matched;
        logic any_active;
    } t_res;

    // One-hot set bit for a state; states past the set width give nothing.
    function automatic logic [STATE_CNT-1:0] st_bit(input logic [STATE_W-1:0] s);
        logic [63:0] wide;
        wide = 64'd1 << s;
        return wide[STATE_CNT-1:0];
    endfunction

endpackage

### src/nelm_edge_ram.sv
// Simple dual-port edge table RAM: one write port, one registered read port.
// Standalone; sized by parameters.
module nelm_edge_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 21
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/nelm_engine.sv
// Matcher engine: edge table writes, move pass and repeated closure passes
// over the edge RAM, one edge per cycle. Depends on nelm_pkg, nelm_edge_ram.
module nelm_engine import nelm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  t_item               i_item,
    input  logic [ECNT_W-1:0]   i_edge_count,
    input  logic [STATE_W-1:0]  i_accept_state,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_res                o_res
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MOVE   = 4'b0010,
        ST_CLOSE  = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [ECNT_W-1:0]    r_addr, n_addr;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_rd_last, n_rd_last;
    logic [STATE_CNT-1:0] r_set, n_set;
    logic [STATE_CNT-1:0] r_next, n_next;
    logic                 r_grew, n_grew;
    logic [SYM_W-1:0]     r_chr, n_chr;

    logic [ECNT_W-1:0]    n_used;
    logic                 accept;
    logic                 wr_en;
    logic                 rd_go;
    t_edge                wr_edge;
    t_edge                rd_edge;
    logic [EDGE_W-1:0]    rd_raw;
    logic                 src_hit;
    logic [STATE_CNT-1:0] dst_bit;
    logic                 move_hit;
    logic                 close_hit;
    logic                 close_grew;
    logic [STATE_CNT-1:0] next_move;
    logic [STATE_CNT-1:0] close_set;
    logic                 pass_end;

    assign n_used = (32'(i_edge_count) > EDGE_CNT) ? ECNT_W'(EDGE_CNT) : i_edge_count;
    assign accept = i_item_valid && o_item_ready;
    assign o_item_ready = (r_state == ST_IDLE);

    assign wr_en   = accept && (i_item.req == REQ_LOAD) && (32'(i_item.idx) < EDGE_CNT);
    assign wr_edge = '{eps: i_item.eps, sym: i_item.sym, src: i_item.src, dst: i_item.dst};
    assign rd_go   = ((r_state == ST_MOVE) || (r_state == ST_CLOSE)) && (r_addr < n_used);

    nelm_edge_ram #(
        .DEPTH (EDGE_CNT),
        .WIDTH (EDGE_W)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (EIDX_W'(i_item.idx)),
        .i_wr_data (wr_edge),
        .i_rd_en   (rd_go),
        .i_rd_addr (r_addr[EIDX_W-1:0]),
        .o_rd_data (rd_raw)
    );

    assign rd_edge    = t_edge'(rd_raw);
    assign src_hit    = |(r_set & st_bit(rd_edge.src));
    assign dst_bit    = st_bit(rd_edge.dst);
    assign move_hit   = r_rd_vld && !rd_edge.eps && (rd_edge.sym == r_chr) && src_hit;
    assign close_hit  = r_rd_vld && rd_edge.eps && src_hit;
    assign close_grew = close_hit && ((r_set & dst_bit) == '0);
    assign next_move  = r_next | (move_hit ? dst_bit : '0);
    assign close_set  = r_set | (close_hit ? dst_bit : '0);
    assign pass_end   = (r_rd_vld && r_rd_last) || (n_used == '0);

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_rd_vld  = rd_go;
        n_rd_last = (r_addr == n_used - ECNT_W'(1));
        n_set     = r_set;
        n_next    = r_next;
        n_grew    = r_grew;
        n_chr     = r_chr;
        if (rd_go) begin
            n_addr = r_addr + ECNT_W'(1);
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.req)
                        REQ_START: begin
                            n_set   = st_bit('0);
                            n_addr  = '0;
                            n_grew  = 1'b0;
                            n_state = ST_CLOSE;
                        end
                        REQ_CHAR: begin
                            n_chr   = i_item.chr;
                            n_next  = '0;
                            n_addr  = '0;
                            n_state = ST_MOVE;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                if (pass_end) begin
                    n_set   = next_move;
                    n_addr  = '0;
                    n_grew  = 1'b0;
                    n_state = ST_CLOSE;
                end else begin
                    n_next = next_move;
                end
            end
            ST_CLOSE: begin
                n_set = close_set;
                if (pass_end) begin
                    n_addr = '0;
                    n_grew = 1'b0;
                    if (!(r_grew || close_grew)) begin
                        n_state = ST_RESULT;
                    end
                end else begin
                    n_grew = r_grew || close_grew;
                end
            end
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_set    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_set    <= n_set;
        end
        r_addr    <= n_addr;
        r_rd_last <= n_rd_last;
        r_next    <= n_next;
        r_grew    <= n_grew;
        r_chr     <= n_chr;
    end

    assign o_res_valid      = (r_state == ST_RESULT);
    assign o_res.matched    = |(r_set & st_bit(i_accept_state));
    assign o_res.any_active = |r_set;

endmodule

### src/nfa_edge_list_matcher.sv
// NFA edge-list matcher top level: config registers, engine, output register.
// Depends on nelm_pkg and nelm_engine.
//
// Usage: items arrive on s_axis (tuser = request kind, tdata = edge and
// character fields). A load item writes one edge slot; a start item sets
// the active set to the epsilon closure of state 0; a character item moves
// the active set over matching edges and then closes it. Each item gives one
// transaction on m_axis with the matched and any-active flags.
// The cfg channel writes edge_count (index 0) and accept_state (index 1);
// write it only while the block is idle. cfg_ready is always high.
// Load and unknown items pass through the result state to the output register.
// With min(edge_count, 128) edges in use, a start item runs closure passes
// over those edges and a character item runs one move pass and then closure
// passes, repeated until a closure pass adds nothing. The edge RAM read
// port gives each pass one edge per cycle.
// One item is in work at a time; the next is taken as soon as the result
// moves to the output register, even while m_axis is stalled.
// Reset clears the active set, config registers and all valid flags; edge
// RAM contents are undefined until loaded.
module nfa_edge_list_matcher import nelm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [6:0] edge_index, [7] edge_is_epsilon, [15:8] edge_symbol,
    // [21:16] edge_source, [27:22] edge_target, [35:28] char_value, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] matched, [1] any_active, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ECNT_W-1:0]  r_edge_count;
    logic [STATE_W-1:0] r_accept_state;
    logic               r_out_valid;
    t_res               r_out;
    t_item              item;
    t_res               res;
    logic               res_valid;
    logic               res_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count   <= '0;
            r_accept_state <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_EDGE_COUNT: r_edge_count   <= i_cfg_data[ECNT_W-1:0];
                REG_ACCEPT:     r_accept_state <= i_cfg_data[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign item.req = t_req'(s_axis_tuser);
    assign item.idx = s_axis_tdata[6:0];
    assign item.eps = s_axis_tdata[7];
    assign item.sym = s_axis_tdata[15:8];
    assign item.src = s_axis_tdata[21:16];
    assign item.dst = s_axis_tdata[27:22];
    assign item.chr = s_axis_tdata[35:28];

    nelm_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (s_axis_tvalid),
        .o_item_ready   (s_axis_tready),
        .i_item         (item),
        .i_edge_count   (r_edge_count),
        .i_accept_state (r_accept_state),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out.any_active, r_out.matched};

endmodule
